// File: design/archive_path_sanitizer_assert.svh
// ----------------------------------------------------------------------------
// Archive path sanitizer assertion macros
// Concurrent assertion wrappers; they compile to nothing when NO_ASSERTIONS
// is defined.
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_PATH_SANITIZER_ASSERT_SVH
`define ARCHIVE_PATH_SANITIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define APS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: design/aps_pkg.sv
// ----------------------------------------------------------------------------
// Archive path sanitizer package
// Shared constants, character codes and structure types.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int CHAR_W            = 8;
  localparam int MAX_LEN_W         = 9;
  localparam int LEN_LIMIT_DEFAULT = 256;
  localparam int SEG_W             = 2;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 9'd64;

  localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CTRL_LIMIT = 8'd32;
  localparam logic [CHAR_W-1:0] CH_CASE_DIFF  = 8'd32;

  localparam logic [SEG_W-1:0] SEG_SAT = 2'd3;
  localparam logic [SEG_W-1:0] SEG_TWO = 2'd2;

  // Per-path segment tracking and the sticky reject flag.
  typedef struct packed {
    logic [SEG_W-1:0] seg_len;
    logic [SEG_W-1:0] seg_dots;
    logic             rejected;
  } seg_state_t;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              done_res;
    logic              verdict;
  } result_t;

endpackage

// File: design/aps_ifs.sv
// ----------------------------------------------------------------------------
// Archive path sanitizer channel interfaces
// Valid/ready channels for the path bytes, the results and the configuration.
// ----------------------------------------------------------------------------
interface aps_in_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              is_end;

  modport source (output valid, char_in, is_end, input ready);
  modport sink (input valid, char_in, is_end, output ready);
endinterface

interface aps_out_if import aps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              char_valid;
  logic              done_res;
  logic              verdict;

  modport source (output valid, char_out, char_valid, done_res, verdict, input ready);
  modport sink (input valid, char_out, char_valid, done_res, verdict, output ready);
endinterface

interface aps_cfg_if import aps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MAX_LEN_W-1:0] max_len;

  modport source (output valid, max_len, input ready);
  modport sink (input valid, max_len, output ready);
endinterface

// File: design/aps_step.sv
// ----------------------------------------------------------------------------
// Archive path sanitizer step logic
// Decides one byte: canonical output, verdict and the next path state.
// ----------------------------------------------------------------------------
module aps_step import aps_pkg::*; #(
  parameter int LEN_LIMIT = LEN_LIMIT_DEFAULT,
  parameter int CNT_W     = $clog2(LEN_LIMIT + 1)
) (
  input  seg_state_t           seg,
  input  logic [CNT_W-1:0]     cnt,
  input  logic [MAX_LEN_W-1:0] max_len,
  input  logic [CHAR_W-1:0]    char_in,
  input  logic                 is_end,
  output seg_state_t           seg_next,
  output logic [CNT_W-1:0]     cnt_next,
  output result_t              res
);

  localparam int CMP_W = ((CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W) + 1;
  localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(LEN_LIMIT);

  logic [CMP_W-1:0] max_len_w;
  logic [CMP_W-1:0] lim;
  logic             room_left;
  logic             seg_bad;
  logic             is_sep;
  logic             is_upper;

  assign max_len_w = CMP_W'(max_len);
  assign lim       = (max_len_w > LIMIT_C) ? LIMIT_C : max_len_w;
  assign room_left = (CMP_W'(cnt) + CMP_W'(1)) < lim;
  assign seg_bad   = (seg.seg_len == '0) ||
                     ((seg.seg_len == SEG_TWO) && (seg.seg_dots == SEG_TWO));
  assign is_sep    = (char_in == CH_SLASH) || (char_in == CH_BACKSLASH);
  assign is_upper  = (char_in >= CH_UPPER_A) && (char_in <= CH_UPPER_Z);

  always_comb begin
    seg_next = seg;
    cnt_next = cnt;
    res      = '0;
    if (is_end) begin
      // The terminator checks the final segment and starts a fresh path.
      res.done_res = 1'b1;
      res.verdict  = seg.rejected || seg_bad;
      seg_next     = '0;
      cnt_next     = '0;
    end else begin
      if (!seg.rejected) begin
        if (is_sep) begin
          if (seg_bad || !room_left) begin
            seg_next.rejected = 1'b1;
          end else begin
            res.char_out      = CH_SLASH;
            res.char_valid    = 1'b1;
            seg_next.seg_len  = '0;
            seg_next.seg_dots = '0;
          end
        end else if ((char_in < CH_CTRL_LIMIT) || (char_in == CH_COLON) || !room_left) begin
          seg_next.rejected = 1'b1;
        end else begin
          res.char_out   = is_upper ? (char_in + CH_CASE_DIFF) : char_in;
          res.char_valid = 1'b1;
          if (seg.seg_len != SEG_SAT) begin
            seg_next.seg_len = seg.seg_len + SEG_W'(1);
          end
          if ((char_in == CH_DOT) && (seg.seg_dots != SEG_SAT)) begin
            seg_next.seg_dots = seg.seg_dots + SEG_W'(1);
          end
        end
        if (res.char_valid) begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      res.verdict = seg_next.rejected;
    end
  end

endmodule

// File: design/archive_path_sanitizer.sv
// ----------------------------------------------------------------------------
// Archive path sanitizer
// Canonicalizes a relative archive path one byte per transfer and rejects
// unsafe paths (colon, control byte, empty or ".." segment, overlong).
// ----------------------------------------------------------------------------
// A byte accepted from path_in waits in the input stage, is decided and
// written to the result register, and transfers out from there.
// Throughput: one byte per cycle; both the input stage and the result
// register advance together whenever the result side is free or draining.
// Reset (rst, synchronous, active high) empties both stages, clears the path
// state and sets max_len to 64.
`include "archive_path_sanitizer_assert.svh"

module archive_path_sanitizer import aps_pkg::*; #(
  parameter int LEN_LIMIT = LEN_LIMIT_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  aps_cfg_if.sink   cfg,
  aps_in_if.sink    path_in,
  aps_out_if.source path_out
);

  // The byte counter must hold every value up to the length limit.
  localparam int CNT_W = $clog2(LEN_LIMIT + 1);

  // Configuration register. Writes must arrive only while the block is idle;
  // the block does not enforce this, and the port is always ready.
  logic [MAX_LEN_W-1:0] max_len;

  // Input stage: the accepted byte waits here while it is decided.
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_end;

  // Path state, updated when the input stage hands its byte to the result
  // register.
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  seg_state_t       seg;
  seg_state_t       seg_next;

  // Result register.
  logic    out_valid;
  result_t out_res;
  result_t res_next;

  logic out_free;
  logic advance;

  // The result register can take a new item when it is empty or its
  // current item transfers out in this cycle.
  assign out_free = !out_valid || path_out.ready;
  assign advance  = s1_valid && out_free;

  assign cfg.ready     = 1'b1;
  assign path_in.ready = !s1_valid || out_free;

  aps_step #(
    .LEN_LIMIT (LEN_LIMIT),
    .CNT_W     (CNT_W)
  ) u_step (
    .seg      (seg),
    .cnt      (cnt),
    .max_len  (max_len),
    .char_in  (s1_char),
    .is_end   (s1_end),
    .seg_next (seg_next),
    .cnt_next (cnt_next),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_len <= cfg.max_len;
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (path_in.ready) begin
      s1_valid <= path_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (path_in.valid && path_in.ready) begin
      s1_char <= path_in.char_in;
      s1_end  <= path_in.is_end;
    end
  end

  // Path state commits exactly once per decided byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      seg <= '0;
    end else if (advance) begin
      cnt <= cnt_next;
      seg <= seg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign path_out.valid      = out_valid;
  assign path_out.char_out   = out_res.char_out;
  assign path_out.char_valid = out_res.char_valid;
  assign path_out.done_res   = out_res.done_res;
  assign path_out.verdict    = out_res.verdict;

  // An emitted byte never carries a reject verdict.
  `APS_ASSERT_NOW(a_emit_not_rejected, clk, rst, out_valid && out_res.char_valid, !out_res.verdict, "emitted byte marked rejected")
  // A terminator result never emits a byte.
  `APS_ASSERT_NOW(a_done_no_char, clk, rst, out_valid && out_res.done_res, !out_res.char_valid, "terminator emitted a byte")
  // The count stays below the length limit.
  `APS_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt < CNT_W'(LEN_LIMIT), "byte count beyond limit")
  // A decided terminator leaves a clean path state.
  `APS_ASSERT_NEXT(a_end_clears, clk, rst, advance && s1_end, (cnt == '0) && (seg == '0), "path state not cleared")
  // A reject sticks until the terminator.
  `APS_ASSERT_NEXT(a_reject_sticky, clk, rst, advance && !s1_end && seg.rejected, seg.rejected, "reject flag dropped")

endmodule
